@@ src/bfa_pkg.sv @@
// Shared constants and types for the best-fit block allocator.
// No dependencies; compiled before every other file of the block.
package bfa_pkg;

    // Default table depth and width of a block size.
    localparam int BLOCKS_DEF    = 16;
    localparam int SIZE_BITS_DEF = 16;

    // Fixed widths of the channel fields.
    localparam int AMOUNT_W   = 16;
    localparam int INDEX_W    = 4;
    localparam int FRAG_OUT_W = 20;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Opcode values of the command channel.
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_ALLOCATE = 1'b1;

    // Classification that the front attaches to each queued command.
    typedef struct packed {
        logic is_alloc;
        logic zero_req;
    } cmd_flags_t;

endpackage

@@ src/bfa_if.sv @@
// Channel interfaces of the best-fit block allocator: command in, result out.
// Depends on bfa_pkg for the field widths.
interface bfa_cmd_if;
    import bfa_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output op, output amount, input ready);
    modport sink (input valid, input op, input amount, output ready);
endinterface

interface bfa_rsp_if;
    import bfa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [INDEX_W-1:0]    block_index;
    logic [FRAG_OUT_W-1:0] fragmentation;

    modport source (output valid, output found, output block_index, output fragmentation,
                    input ready);
    modport sink (input valid, input found, input block_index, input fragmentation,
                  output ready);
endinterface

@@ src/bfa_front.sv @@
// Front end: accepts commands, masks and classifies them, and queues them.
// Depends on bfa_pkg and bfa_cmd_if.
module bfa_front #(
    parameter int SIZE_BITS = bfa_pkg::SIZE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bfa_cmd_if.sink               cmd,
    output logic                  q_valid,
    output bfa_pkg::cmd_flags_t   q_flags,
    output logic [SIZE_BITS-1:0]  q_amt,
    input  logic                  q_pop
);
    import bfa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_flags_t           flags_mem [QUEUE_DEPTH];
    logic [SIZE_BITS-1:0] amt_mem   [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                 push;
    logic [SIZE_BITS-1:0] amt_in;
    cmd_flags_t           flags_in;

    // Only the low SIZE_BITS bits of the amount take part.
    assign amt_in            = SIZE_BITS'(cmd.amount);
    assign flags_in.is_alloc = (cmd.op == OP_ALLOCATE);
    assign flags_in.zero_req = (amt_in == '0);

    assign cmd.ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = cmd.valid && cmd.ready;

    assign q_valid = (cnt_reg != '0);
    assign q_flags = flags_mem[rd_ptr_reg];
    assign q_amt   = amt_mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flags_mem[wr_ptr_reg] <= flags_in;
            amt_mem[wr_ptr_reg]   <= amt_in;
        end
    end

endmodule

@@ src/bfa_back.sv @@
// Back end: block size memory, best-fit scan, update and result register.
// Depends on bfa_pkg and bfa_rsp_if.
module bfa_back #(
    parameter int BLOCKS    = bfa_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = bfa_pkg::SIZE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  bfa_pkg::cmd_flags_t   q_flags,
    input  logic [SIZE_BITS-1:0]  q_amt,
    output logic                  q_pop,
    bfa_rsp_if.source             rsp
);
    import bfa_pkg::*;

    localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int FRAG_W = SIZE_BITS + CNT_W;
    localparam int EXT_W  = (FRAG_W > FRAG_OUT_W) ? FRAG_W : FRAG_OUT_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Remaining size of each block; entries at or above the count are never read.
    logic [SIZE_BITS-1:0] size_mem [BLOCKS];
    logic [SIZE_BITS-1:0] rd_data_reg;

    logic [2:0]           state_reg, state_next;
    logic [SIZE_BITS-1:0] amt_reg, amt_next;
    logic                 zero_reg, zero_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BLOCKS-1:0]    touched_reg, touched_next;
    logic [FRAG_W-1:0]    frag_reg, frag_next;
    logic [CNT_W-1:0]     iss_reg, iss_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 have_reg, have_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    logic [SIZE_BITS-1:0] diff_reg, diff_next;

    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic [FRAG_OUT_W-1:0] out_frag_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  res_found;
    logic [IDX_W-1:0]      res_index;
    logic                  rd_en;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [SIZE_BITS-1:0]  mem_wd;
    logic [EXT_W-1:0]      frag_ext;
    logic [FRAG_OUT_W-1:0] frag_sat;

    assign out_free = !out_valid_reg || rsp.ready;

    // Sequencer: load, or scan every loaded block and update the best fit.
    always_comb
    begin
        state_next     = state_reg;
        amt_next       = amt_reg;
        zero_next      = zero_reg;
        count_next     = count_reg;
        touched_next   = touched_reg;
        frag_next      = frag_reg;
        iss_next       = iss_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        diff_next      = diff_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = best_reg;
        mem_wd         = diff_reg;
        out_load       = 1'b0;
        res_found      = 1'b0;
        res_index      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    amt_next  = q_amt;
                    zero_next = q_flags.zero_req;
                    iss_next  = '0;
                    have_next = 1'b0;
                    best_next = '0;
                    state_next = q_flags.is_alloc ? S_SCAN : S_LOAD;
                end
            end

            S_LOAD:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (count_reg != CNT_W'(BLOCKS))
                    begin
                        mem_we     = 1'b1;
                        mem_wa     = count_reg[IDX_W-1:0];
                        mem_wd     = amt_reg;
                        touched_next[count_reg[IDX_W-1:0]] = 1'b0;
                        count_next = count_reg + 1'b1;
                        res_found  = 1'b1;
                        res_index  = count_reg[IDX_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle; compare the entry read the cycle before.
                if (iss_reg != count_reg)
                begin
                    rd_en    = 1'b1;
                    iss_next = iss_reg + 1'b1;
                end
                cmp_vld_next = rd_en;
                cmp_idx_next = iss_reg[IDX_W-1:0];
                if (cmp_vld_reg && (rd_data_reg >= amt_reg) &&
                    (!have_reg || (rd_data_reg < best_size_reg)))
                begin
                    have_next      = 1'b1;
                    best_next      = cmp_idx_reg;
                    best_size_next = rd_data_reg;
                end
                if ((iss_reg == count_reg) && !cmp_vld_reg)
                begin
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                diff_next  = best_size_reg - amt_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    res_found = have_reg;
                    res_index = have_reg ? best_reg : '0;
                    if (have_reg && !zero_reg)
                    begin
                        mem_we = 1'b1;
                        if (touched_reg[best_reg])
                        begin
                            frag_next = frag_reg - FRAG_W'(amt_reg);
                        end
                        else
                        begin
                            frag_next = frag_reg + FRAG_W'(diff_reg);
                            touched_next[best_reg] = 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Saturate the running total to the width of the result field.
    assign frag_ext = EXT_W'(frag_next);
    assign frag_sat = (|frag_ext[EXT_W-1:FRAG_OUT_W]) ? '1 : frag_ext[FRAG_OUT_W-1:0];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            touched_reg   <= '0;
            frag_reg      <= '0;
            iss_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            touched_reg <= touched_next;
            frag_reg    <= frag_next;
            iss_reg     <= iss_next;
            cmp_vld_reg <= cmp_vld_next;
            have_reg    <= have_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        amt_reg       <= amt_next;
        zero_reg      <= zero_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
        diff_reg      <= diff_next;
        if (out_load)
        begin
            out_found_reg <= res_found;
            out_index_reg <= INDEX_W'(res_index);
            out_frag_reg  <= frag_sat;
        end
    end

    // Size memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= size_mem[iss_reg[IDX_W-1:0]];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.block_index   = out_index_reg;
    assign rsp.fragmentation = out_frag_reg;

endmodule

@@ src/best_fit_block_allocator.sv @@
// A load passes the back end through the idle and load states; an allocate over the loaded
// blocks passes through idle, scan, calc and done, its length set by the serial scan
// through the single read port of the block size memory. The result is registered and
// shows in the cycle after the last step.
// A two-entry command queue keeps accepting, until it is full, while the back end works or a result waits.
// Reset (rst_n low, asynchronous) empties the table and the queue, clears fragmentation and the touched flags.
module best_fit_block_allocator #(
    parameter int BLOCKS    = bfa_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = bfa_pkg::SIZE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bfa_cmd_if.sink    cmd,
    bfa_rsp_if.source  rsp
);
    import bfa_pkg::*;

    logic                 q_valid;
    cmd_flags_t           q_flags;
    logic [SIZE_BITS-1:0] q_amt;
    logic                 q_pop;

    // Command intake and queue.
    bfa_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_flags (q_flags),
        .q_amt   (q_amt),
        .q_pop   (q_pop)
    );

    // Table, scan and result.
    bfa_back #(
        .BLOCKS    (BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_flags (q_flags),
        .q_amt   (q_amt),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

@@ src/bfa_checker.sv @@
// Port-level checks of the best-fit block allocator, bound to the top level.
// Depends on bfa_pkg for the field widths.
module bfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic                           rsp_found,
    input logic [bfa_pkg::INDEX_W-1:0]    rsp_block_index,
    input logic [bfa_pkg::FRAG_OUT_W-1:0] rsp_fragmentation
);
    import bfa_pkg::*;

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_found) && $stable(rsp_block_index) && $stable(rsp_fragmentation))
        else $error("result changed while stalled");

    // A miss always reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_block_index == '0)
        else $error("miss with nonzero block index");

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result offered during reset");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_found         (rsp.found),
    .rsp_block_index   (rsp.block_index),
    .rsp_fragmentation (rsp.fragmentation)
);
